// ===== rtl/fat32_root_dir_entry_walker_top_macros.svh =====
// Assertion macros for the FAT32 root directory walker.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef FAT32_ROOT_DIR_ENTRY_WALKER_TOP_MACROS_SVH
`define FAT32_ROOT_DIR_ENTRY_WALKER_TOP_MACROS_SVH

// same-cycle implication
`define F32RDW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define F32RDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/f32rdw_pkg.sv =====
// Shared types and constants of the FAT32 root directory walker.
// No dependencies; imported by every other file except the assertion macros header.
package f32rdw_pkg;

    localparam int BPS_W     = 13;
    localparam int SPC_W     = 8;
    localparam int RSC_W     = 16;
    localparam int FC_W      = 8;
    localparam int SPT_W     = 32;
    localparam int RET_W     = 16;
    localparam int CLU_W     = 32;
    localparam int FAT_W     = 32;
    localparam int OFF_W     = 20;
    localparam int ADDR_W    = 33;
    localparam int TAB_W     = 32;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int UPC_W     = 4;

    localparam int ENTRY_BYTES_DEF = 32;

    localparam logic [BPS_W-1:0] BPS_RST = BPS_W'(512);
    localparam logic [SPC_W-1:0] SPC_RST = SPC_W'(1);
    localparam logic [RSC_W-1:0] RSC_RST = RSC_W'(32);
    localparam logic [FC_W-1:0]  FC_RST  = FC_W'(2);
    localparam logic [SPT_W-1:0] SPT_RST = '0;
    localparam logic [RET_W-1:0] RET_RST = '0;
    localparam logic [CLU_W-1:0] ROOT_RST = CLU_W'(2);

    localparam logic [CLU_W-1:0] EOC_MARK     = 32'h0FFF_FFF8;
    localparam logic [CLU_W-1:0] CLUSTER_MASK = 32'h0FFF_FFFF;
    localparam logic [CLU_W-1:0] CLUSTER_BASE = CLU_W'(2);
    localparam int               FAT_SHIFT    = 2;   // four bytes per FAT entry

    localparam logic MODE_BEGIN = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPS  = 3'd0,
        CFG_SPC  = 3'd1,
        CFG_RSC  = 3'd2,
        CFG_FC   = 3'd3,
        CFG_SPT  = 3'd4,
        CFG_RET  = 3'd5,
        CFG_ROOT = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_ADV,
        UOP_B_INIT,
        UOP_DIV,
        UOP_B_SUM,
        UOP_B_FIN,
        UOP_O_MUL0,
        UOP_O_MUL1,
        UOP_O_MUL2,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_LOOP,
        JMP_HOLD
    } jmp_t;

    typedef struct packed {
        uop_t             op;
        jmp_t             jmp;
        logic [UPC_W-1:0] target;
        logic             wait_in;
    } ctrl_t;

    typedef struct packed {
        logic div_last;
        logic out_full;
    } stat_t;

endpackage

// ===== rtl/f32rdw_if.sv =====
// Valid/ready channel interfaces for the walker's item and result words.
// Depends on f32rdw_pkg.
interface f32rdw_item_if;
    import f32rdw_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [FAT_W-1:0] fat_value;

    modport source (output valid, output mode, output fat_value, input ready);
    modport sink   (input valid, input mode, input fat_value, output ready);
endinterface

interface f32rdw_result_if;
    import f32rdw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] entry_address;
    logic [TAB_W-1:0]  table_entry_address;
    logic [CLU_W-1:0]  current_cluster;
    logic              chain_end;

    modport source (output valid, output entry_address, output table_entry_address,
                    output current_cluster, output chain_end, input ready);
    modport sink   (input valid, input entry_address, input table_entry_address,
                    input current_cluster, input chain_end, output ready);
endinterface

// ===== rtl/f32rdw_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on f32rdw_pkg.
module f32rdw_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    input  f32rdw_pkg::stat_t   stat,
    output f32rdw_pkg::ctrl_t   cw,
    output logic                in_ready
);
    import f32rdw_pkg::*;

    localparam logic [UPC_W-1:0] STEP_IDLE   = UPC_W'(0);
    localparam logic [UPC_W-1:0] STEP_ADV    = UPC_W'(1);
    localparam logic [UPC_W-1:0] STEP_B_INIT = UPC_W'(2);
    localparam logic [UPC_W-1:0] STEP_B_DIV  = UPC_W'(3);
    localparam logic [UPC_W-1:0] STEP_B_SUM  = UPC_W'(4);
    localparam logic [UPC_W-1:0] STEP_B_FIN  = UPC_W'(5);
    localparam logic [UPC_W-1:0] STEP_O_MUL0 = UPC_W'(6);
    localparam logic [UPC_W-1:0] STEP_O_MUL1 = UPC_W'(7);
    localparam logic [UPC_W-1:0] STEP_O_MUL2 = UPC_W'(8);
    localparam logic [UPC_W-1:0] STEP_EMIT   = UPC_W'(9);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;

    // control store
    always_comb
    begin
        case (upc_reg)
            STEP_IDLE:   cw = '{op: UOP_NONE,   jmp: JMP_DISPATCH, target: STEP_B_INIT, wait_in: 1'b1};
            STEP_ADV:    cw = '{op: UOP_ADV,    jmp: JMP_GOTO,     target: STEP_O_MUL0, wait_in: 1'b0};
            STEP_B_INIT: cw = '{op: UOP_B_INIT, jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_B_DIV:  cw = '{op: UOP_DIV,    jmp: JMP_LOOP,     target: STEP_B_DIV,  wait_in: 1'b0};
            STEP_B_SUM:  cw = '{op: UOP_B_SUM,  jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_B_FIN:  cw = '{op: UOP_B_FIN,  jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_O_MUL0: cw = '{op: UOP_O_MUL0, jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_O_MUL1: cw = '{op: UOP_O_MUL1, jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_O_MUL2: cw = '{op: UOP_O_MUL2, jmp: JMP_NEXT,     target: STEP_IDLE,   wait_in: 1'b0};
            STEP_EMIT:   cw = '{op: UOP_EMIT,   jmp: JMP_HOLD,     target: STEP_IDLE,   wait_in: 1'b0};
            default:     cw = '{op: UOP_NONE,   jmp: JMP_GOTO,     target: STEP_IDLE,   wait_in: 1'b0};
        endcase
    end

    assign in_ready = cw.wait_in;
    assign upc_inc  = upc_reg + UPC_W'(1);

    always_comb
    begin
        case (cw.jmp)
            JMP_NEXT:     upc_next = upc_inc;
            JMP_GOTO:     upc_next = cw.target;
            JMP_DISPATCH: upc_next = !in_valid ? upc_reg :
                                     (in_mode == MODE_BEGIN) ? cw.target : upc_inc;
            JMP_LOOP:     upc_next = stat.div_last ? upc_inc : cw.target;
            JMP_HOLD:     upc_next = stat.out_full ? upc_reg : cw.target;
            default:      upc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/f32rdw_dp.sv =====
// Datapath: boot-sector registers, walk state, shared multiplier,
// bit-serial divider and output register. Depends on f32rdw_pkg.
module f32rdw_dp #(
    parameter int ENTRY_BYTES = f32rdw_pkg::ENTRY_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [f32rdw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [f32rdw_pkg::WORD_W-1:0]    cfg_data,
    input  logic                             in_accept,
    input  logic [f32rdw_pkg::FAT_W-1:0]     in_fat_value,
    input  f32rdw_pkg::ctrl_t                cw,
    output f32rdw_pkg::stat_t                stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [f32rdw_pkg::ADDR_W-1:0]    out_entry_address,
    output logic [f32rdw_pkg::TAB_W-1:0]     out_table_entry_address,
    output logic [f32rdw_pkg::CLU_W-1:0]     out_current_cluster,
    output logic                             out_chain_end
);
    import f32rdw_pkg::*;

    // boot-sector registers
    logic [BPS_W-1:0] bps_reg;
    logic [SPC_W-1:0] spc_reg;
    logic [RSC_W-1:0] rsc_reg;
    logic [FC_W-1:0]  fc_reg;
    logic [SPT_W-1:0] spt_reg;
    logic [RET_W-1:0] ret_reg;
    logic [CLU_W-1:0] root_reg;

    // walk state
    logic [CLU_W-1:0]  cluster_reg,  cluster_next;
    logic [OFF_W-1:0]  offset_reg,   offset_next;
    logic [WORD_W-1:0] dss_reg,      dss_next;
    logic [OFF_W-1:0]  cbytes_reg,   cbytes_next;
    logic              done_reg,     done_next;

    // working registers
    logic [FAT_W-1:0]  fat_reg;
    logic [WORD_W-1:0] mul_reg,      mul_next;
    logic [WORD_W-1:0] acc_reg,      acc_next;
    logic [BPS_W-1:0]  rem_reg,      rem_next;
    logic [DIV_W-1:0]  quo_reg,      quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] oea_reg;
    logic [TAB_W-1:0]  otab_reg;
    logic [CLU_W-1:0]  oclu_reg;
    logic              oend_reg;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic [OFF_W:0]             off_sum;
    logic [BPS_W:0]             rem_sh;
    logic                       rem_ge;
    logic [CLU_W-1:0]           fat_masked;
    logic                       bps_zero;
    logic                       out_full;
    logic                       out_load;

    assign bps_zero   = (bps_reg == '0);
    assign off_sum    = {1'b0, offset_reg} + (OFF_W+1)'(ENTRY_BYTES);
    assign fat_masked = fat_reg & CLUSTER_MASK;
    assign rem_sh     = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge     = (rem_sh >= {1'b0, bps_reg});
    assign out_full   = out_valid_reg && !out_ready;
    assign out_load   = (cw.op == UOP_EMIT) && !out_full;

    assign stat.div_last = (cnt_reg == DIV_CNT_W'(DIV_W - 1));
    assign stat.out_full = out_full;

    // shared multiplier operand selection
    always_comb
    begin
        case (cw.op)
            UOP_B_INIT: begin mul_a = spt_reg;                       mul_b = MUL_B_W'(fc_reg);  end
            UOP_B_SUM:  begin mul_a = MUL_A_W'(bps_reg);             mul_b = MUL_B_W'(spc_reg); end
            UOP_O_MUL0: begin mul_a = cluster_reg - CLUSTER_BASE;    mul_b = MUL_B_W'(spc_reg); end
            UOP_O_MUL1: begin mul_a = MUL_A_W'(bps_reg);             mul_b = rsc_reg;           end
            UOP_O_MUL2: begin mul_a = acc_reg;                       mul_b = MUL_B_W'(bps_reg); end
            default:    begin mul_a = '0;                            mul_b = '0;                end
        endcase
    end

    assign mul_full = (MUL_A_W+MUL_B_W)'(mul_a) * (MUL_A_W+MUL_B_W)'(mul_b);

    always_comb
    begin
        cluster_next = cluster_reg;
        offset_next  = offset_reg;
        dss_next     = dss_reg;
        cbytes_next  = cbytes_reg;
        done_next    = done_reg;
        mul_next     = mul_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        case (cw.op)
            UOP_ADV:
            begin
                if (cluster_reg >= EOC_MARK)
                begin
                    done_next = 1'b1;
                end
                else if (off_sum < {1'b0, cbytes_reg})
                begin
                    offset_next = off_sum[OFF_W-1:0];
                    done_next   = 1'b0;
                end
                else
                begin
                    cluster_next = fat_masked;
                    offset_next  = '0;
                    done_next    = (fat_masked >= EOC_MARK);
                end
            end
            UOP_B_INIT:
            begin
                // dividend: root entries times entry size plus sector size less one
                mul_next = mul_full[WORD_W-1:0];
                quo_next = DIV_W'(32'(ret_reg) * 32'(ENTRY_BYTES)) + DIV_W'(bps_reg)
                           - DIV_W'(1);
                rem_next = '0;
                cnt_next = '0;
            end
            UOP_DIV:
            begin
                rem_next = rem_ge ? BPS_W'(rem_sh - {1'b0, bps_reg}) : rem_sh[BPS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], rem_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
            UOP_B_SUM:
            begin
                acc_next = WORD_W'(rsc_reg) + mul_reg;
                mul_next = mul_full[WORD_W-1:0];
            end
            UOP_B_FIN:
            begin
                dss_next     = acc_reg + (bps_zero ? '0 : quo_reg);
                cbytes_next  = mul_reg[OFF_W-1:0];
                cluster_next = root_reg;
                offset_next  = '0;
                done_next    = (root_reg >= EOC_MARK);
            end
            UOP_O_MUL0:
            begin
                mul_next = mul_full[WORD_W-1:0];
            end
            UOP_O_MUL1:
            begin
                acc_next = mul_reg + dss_reg;
                mul_next = mul_full[WORD_W-1:0];
            end
            UOP_O_MUL2:
            begin
                // (reserved + off/bps)*bps + off%bps folds to reserved*bps + off
                mul_next = mul_full[WORD_W-1:0];
                acc_next = bps_zero ? '0 : mul_reg + (cluster_reg << FAT_SHIFT);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg       <= BPS_RST;
            spc_reg       <= SPC_RST;
            rsc_reg       <= RSC_RST;
            fc_reg        <= FC_RST;
            spt_reg       <= SPT_RST;
            ret_reg       <= RET_RST;
            root_reg      <= ROOT_RST;
            cluster_reg   <= '0;
            offset_reg    <= '0;
            dss_reg       <= '0;
            cbytes_reg    <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BPS:  bps_reg  <= cfg_data[BPS_W-1:0];
                    CFG_SPC:  spc_reg  <= cfg_data[SPC_W-1:0];
                    CFG_RSC:  rsc_reg  <= cfg_data[RSC_W-1:0];
                    CFG_FC:   fc_reg   <= cfg_data[FC_W-1:0];
                    CFG_SPT:  spt_reg  <= cfg_data[SPT_W-1:0];
                    CFG_RET:  ret_reg  <= cfg_data[RET_W-1:0];
                    CFG_ROOT: root_reg <= cfg_data[CLU_W-1:0];
                    default:  ;
                endcase
            end
            cluster_reg   <= cluster_next;
            offset_reg    <= offset_next;
            dss_reg       <= dss_next;
            cbytes_reg    <= cbytes_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fat_reg <= in_fat_value;
        end
        mul_reg <= mul_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (out_load)
        begin
            oea_reg  <= {1'b0, mul_reg} + ADDR_W'(offset_reg);
            otab_reg <= acc_reg;
            oclu_reg <= cluster_reg;
            oend_reg <= done_reg;
        end
    end

    assign out_valid               = out_valid_reg;
    assign out_entry_address       = oea_reg;
    assign out_table_entry_address = otab_reg;
    assign out_current_cluster     = oclu_reg;
    assign out_chain_end           = oend_reg;

endmodule

// ===== rtl/fat32_root_dir_entry_walker_top.sv =====
// Advance word: the advance step, then the address steps O_MUL0 to O_MUL2 and emit.
// Begin word: init, 32-bit bit-serial divide, sum, finish, then address steps and emit.
// Single shared 32x16 multiplier, at most one product per step; only idle takes words.
// A stalled result holds the sequencer in its emit step until taken.
// Reset (rst_n low, asynchronous) restores the boot-sector registers, clears walk state.
`include "fat32_root_dir_entry_walker_top_macros.svh"

module fat32_root_dir_entry_walker_top #(
    parameter int ENTRY_BYTES = f32rdw_pkg::ENTRY_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    f32rdw_item_if.sink                      item,
    f32rdw_result_if.source                  result,
    input  logic                             cfg_we,
    input  logic [f32rdw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [f32rdw_pkg::WORD_W-1:0]    cfg_data
);
    import f32rdw_pkg::*;

    // Control store word and datapath status between the two halves.
    ctrl_t cw;
    stat_t stat;
    logic  item_accept;

    assign item_accept = item.valid && item.ready;

    // Sequencer: step 0 waits for a word, then dispatches to the begin
    // routine (root sector division, data start, cluster size) or the
    // advance step; both fall into the common address steps and emit.
    f32rdw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .stat     (stat),
        .cw       (cw),
        .in_ready (item.ready)
    );

    // Datapath: registers, shared multiplier, divider, output register.
    f32rdw_dp #(
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .in_accept               (item_accept),
        .in_fat_value            (item.fat_value),
        .cw                      (cw),
        .stat                    (stat),
        .out_valid               (result.valid),
        .out_ready               (result.ready),
        .out_entry_address       (result.entry_address),
        .out_table_entry_address (result.table_entry_address),
        .out_current_cluster     (result.current_cluster),
        .out_chain_end           (result.chain_end)
    );

    // A taken word moves the sequencer off its wait step.
    `F32RDW_ASSERT_NEXT(a_leave_wait, item_accept, !item.ready, "ready held after accept")
    // An emit step with room in the output register presents a result.
    `F32RDW_ASSERT_NEXT(a_emit_valid, (cw.op == UOP_EMIT) && !stat.out_full, result.valid, "emit lost")
    // End flag always matches the reported cluster.
    `F32RDW_ASSERT_NOW(a_end_flag, result.valid, result.chain_end == (result.current_cluster >= EOC_MARK), "chain_end mismatch")

endmodule
